// ----- rtl/tasu_pkg.sv -----
package tasu_pkg;

  localparam int unsigned SEC_W  = 64;
  localparam int unsigned NSEC_W = 31;
  // Working width of the nanosecond sum: holds twice the largest magnitude.
  localparam int unsigned NACC_W = 32;

  // Bit positions of the operation code.
  localparam int unsigned KIND_SUB_BIT = 0;
  localparam int unsigned KIND_SAT_BIT = 1;

  localparam logic [SEC_W-1:0] SEC_MAX = {1'b0, {(SEC_W-1){1'b1}}};
  localparam logic [SEC_W-1:0] SEC_MIN = {1'b1, {(SEC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    SAT_NONE,
    SAT_LO,
    SAT_HI
  } sat_e;

  typedef struct packed {
    sat_e                      flag;
    logic                      sat;
    logic                      up;
    logic [SEC_W-1:0]          s;
    logic signed [NACC_W-1:0]  n;
  } sum_t;

  typedef struct packed {
    sat_e                      flag;
    logic [SEC_W-1:0]          s;
    logic signed [NACC_W-1:0]  n;
  } carry_t;

endpackage

// ----- rtl/timespec_add_sub_saturating_unit.sv -----
// Adds or subtracts two signed time values (seconds plus nanoseconds of the
// same sign) and renormalises the result; kind selects add, subtract and their
// saturating forms, which clamp to the most negative or most positive time.
//
// Both channels are valid/ready. An input transaction is taken when
// in_valid_i and in_ready_o are high; a result is handed over when
// out_valid_o and out_ready_i are high. Every input gives exactly one result.
//
// The operands are captured in an input register. The sum with its seconds
// overflow check, the nanosecond carry and the sign correction are worked out
// in one combinational pass into the result register, which drives out_valid_o
// and loads from the input register. One transaction is accepted per cycle while
// the receiver keeps up.
//
// When the receiver stalls, the result register holds its value and the input
// register fills behind it; in_ready_o falls only once both are full.
// Reset empties both registers; no result is lost or duplicated across a stall.
module timespec_add_sub_saturating_unit #(
  parameter int unsigned NsecPerSec = 1000000000
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         kind_i,
  input  logic signed [tasu_pkg::SEC_W-1:0]  a_sec_i,
  input  logic signed [tasu_pkg::NSEC_W-1:0] a_nsec_i,
  input  logic signed [tasu_pkg::SEC_W-1:0]  b_sec_i,
  input  logic signed [tasu_pkg::NSEC_W-1:0] b_nsec_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [tasu_pkg::SEC_W-1:0]  res_sec_o,
  output logic signed [tasu_pkg::NSEC_W-1:0] res_nsec_o
);
  import tasu_pkg::*;

  logic                     v0_q, vo_q;
  logic                     en0, eno;
  logic [1:0]               kind_q;
  logic signed [SEC_W-1:0]  a_sec_q, b_sec_q;
  logic signed [NSEC_W-1:0] a_nsec_q, b_nsec_q;
  sum_t                     sum_d;
  carry_t                   carry_d;
  logic signed [SEC_W-1:0]  res_sec_d, res_sec_q;
  logic signed [NSEC_W-1:0] res_nsec_d, res_nsec_q;

  // A register may load whenever it is empty or the one after it moves on.
  assign eno        = !vo_q || out_ready_i;
  assign en0        = !v0_q || eno;
  assign in_ready_o = en0;

  tasu_sum #(.NsecPerSec(NsecPerSec)) u_sum (
    .kind_i   (kind_q),
    .a_sec_i  (a_sec_q),
    .a_nsec_i (a_nsec_q),
    .b_sec_i  (b_sec_q),
    .b_nsec_i (b_nsec_q),
    .sum_o    (sum_d)
  );

  tasu_carry #(.NsecPerSec(NsecPerSec)) u_carry (
    .sum_i   (sum_d),
    .carry_o (carry_d)
  );

  tasu_norm #(.NsecPerSec(NsecPerSec)) u_norm (
    .carry_i    (carry_d),
    .res_sec_o  (res_sec_d),
    .res_nsec_o (res_nsec_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (eno) vo_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      kind_q   <= kind_i;
      a_sec_q  <= a_sec_i;
      a_nsec_q <= a_nsec_i;
      b_sec_q  <= b_sec_i;
      b_nsec_q <= b_nsec_i;
    end
    if (eno && v0_q) begin
      res_sec_q  <= res_sec_d;
      res_nsec_q <= res_nsec_d;
    end
  end

  assign out_valid_o = vo_q;
  assign res_sec_o   = res_sec_q;
  assign res_nsec_o  = res_nsec_q;

endmodule

// ----- rtl/tasu_sum.sv -----
module tasu_sum #(
  parameter int unsigned NsecPerSec = 1000000000
) (
  input  logic [1:0]                         kind_i,
  input  logic signed [tasu_pkg::SEC_W-1:0]  a_sec_i,
  input  logic signed [tasu_pkg::NSEC_W-1:0] a_nsec_i,
  input  logic signed [tasu_pkg::SEC_W-1:0]  b_sec_i,
  input  logic signed [tasu_pkg::NSEC_W-1:0] b_nsec_i,
  output tasu_pkg::sum_t                     sum_o
);
  import tasu_pkg::*;

  localparam logic signed [NACC_W-1:0] Lim = NACC_W'(NsecPerSec - 1);

  function automatic logic signed [NACC_W-1:0] clamp_nsec(
    input logic signed [NSEC_W-1:0] raw
  );
    logic signed [NACC_W-1:0] v;
    v = NACC_W'(raw);
    if (v > Lim) v = Lim;
    if (v < -Lim) v = -Lim;
    return v;
  endfunction

  logic                     sub, sat;
  logic signed [NACC_W-1:0] an, bn;
  logic [SEC_W-1:0]         s;
  logic                     sa, sb, sr, ovf, b_nonneg;

  always_comb begin
    sub = kind_i[KIND_SUB_BIT];
    sat = kind_i[KIND_SAT_BIT];
    an  = clamp_nsec(a_nsec_i);
    bn  = clamp_nsec(b_nsec_i);
    s   = sub ? (a_sec_i - b_sec_i) : (a_sec_i + b_sec_i);

    sa  = !a_sec_i[SEC_W-1];
    sb  = !b_sec_i[SEC_W-1];
    sr  = !s[SEC_W-1];
    ovf = sub ? (sa != sb && sa != sr) : (sa == sb && sa != sr);

    // The direction of the nanosecond carry follows the sign of the effective operand b.
    b_nonneg = sb && (bn >= 0);

    sum_o.sat  = sat;
    sum_o.up   = sub ? !b_nonneg : b_nonneg;
    sum_o.s    = s;
    sum_o.n    = sub ? (an - bn) : (an + bn);
    sum_o.flag = SAT_NONE;
    if (sat && ovf) begin
      sum_o.flag = sr ? SAT_LO : SAT_HI;
    end
  end

endmodule

// ----- rtl/tasu_carry.sv -----
module tasu_carry #(
  parameter int unsigned NsecPerSec = 1000000000
) (
  input  tasu_pkg::sum_t   sum_i,
  output tasu_pkg::carry_t carry_o
);
  import tasu_pkg::*;

  localparam logic signed [NACC_W-1:0] Ns = NACC_W'(NsecPerSec);

  logic spos, c;

  always_comb begin
    carry_o.flag = sum_i.flag;
    carry_o.s    = sum_i.s;
    carry_o.n    = sum_i.n;
    spos         = !sum_i.s[SEC_W-1] && (sum_i.s != '0);
    c            = 1'b0;

    if (sum_i.flag == SAT_NONE) begin
      if (sum_i.up) begin
        c = !sum_i.s[SEC_W-1] ? (sum_i.n >= Ns) : (sum_i.n > 0);
        if (c) begin
          if (sum_i.sat && sum_i.s == SEC_MAX) begin
            carry_o.flag = SAT_HI;
          end else begin
            carry_o.s = sum_i.s + SEC_W'(1);
            carry_o.n = sum_i.n - Ns;
          end
        end
      end else begin
        c = spos ? (sum_i.n < 0) : (sum_i.n <= -Ns);
        if (c) begin
          if (sum_i.sat && sum_i.s == SEC_MIN) begin
            carry_o.flag = SAT_LO;
          end else begin
            carry_o.s = sum_i.s - SEC_W'(1);
            carry_o.n = sum_i.n + Ns;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/tasu_norm.sv -----
module tasu_norm #(
  parameter int unsigned NsecPerSec = 1000000000
) (
  input  tasu_pkg::carry_t                   carry_i,
  output logic signed [tasu_pkg::SEC_W-1:0]  res_sec_o,
  output logic signed [tasu_pkg::NSEC_W-1:0] res_nsec_o
);
  import tasu_pkg::*;

  localparam logic signed [NACC_W-1:0] Ns  = NACC_W'(NsecPerSec);
  localparam logic signed [NACC_W-1:0] Lim = NACC_W'(NsecPerSec - 1);

  logic [SEC_W-1:0]         s;
  logic signed [NACC_W-1:0] n;

  always_comb begin
    s = carry_i.s;
    n = carry_i.n;
    // Borrow or lend one second so that the nanoseconds take the sign of the seconds.
    if (s[SEC_W-1] && n > 0) begin
      s = s + SEC_W'(1);
      n = n - Ns;
    end else if (!s[SEC_W-1] && s != '0 && n < 0) begin
      s = s - SEC_W'(1);
      n = n + Ns;
    end

    unique case (carry_i.flag)
      SAT_HI: begin
        res_sec_o  = SEC_MAX;
        res_nsec_o = Lim[NSEC_W-1:0];
      end
      SAT_LO: begin
        res_sec_o  = SEC_MIN;
        res_nsec_o = NSEC_W'(-Lim);
      end
      SAT_NONE: begin
        res_sec_o  = s;
        res_nsec_o = n[NSEC_W-1:0];
      end
      default: begin
        res_sec_o  = s;
        res_nsec_o = n[NSEC_W-1:0];
      end
    endcase
  end

endmodule

// ----- rtl/tasu_checker.sv -----
module tasu_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [tasu_pkg::SEC_W-1:0]  res_sec_o,
  input logic signed [tasu_pkg::NSEC_W-1:0] res_nsec_o
);
  import tasu_pkg::*;

  localparam int unsigned Depth = 2;

  logic [1:0] pending_q;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // Transactions accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_fire && !out_fire) begin
      pending_q <= pending_q + 2'd1;
    end else if (!in_fire && out_fire) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(res_sec_o) && $stable(res_nsec_o))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result shown with no transaction outstanding");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 2'(Depth))
    else $error("more transactions in flight than pipeline stages");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && pending_q == 2'(Depth))
    else $error("input stalled while the pipeline can move");

endmodule

bind timespec_add_sub_saturating_unit tasu_checker u_tasu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .res_sec_o   (res_sec_o),
  .res_nsec_o  (res_nsec_o)
);

// ----- bench/timespec_add_sub_saturating_unit_tb.sv -----
`timescale 1ns / 1ps

module timespec_add_sub_saturating_unit_tb;

  localparam int unsigned SW = tasu_pkg::SEC_W;
  localparam int unsigned NW = tasu_pkg::NSEC_W;

  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_SUB     = 2'd1;
  localparam logic [1:0] KIND_SAT_ADD = 2'd2;
  localparam logic [1:0] KIND_SAT_SUB = 2'd3;

  localparam longint NS_PER_SEC  = 1000000000;
  localparam int     STALL_LIMIT = 2000;
  localparam int     LONG_HOLD   = 300;

  typedef struct {
    logic [1:0]           kind;
    logic signed [SW-1:0] a_sec;
    logic signed [NW-1:0] a_nsec;
    logic signed [SW-1:0] b_sec;
    logic signed [NW-1:0] b_nsec;
  } operands_t;

  typedef struct {
    logic [SW-1:0] sec;
    logic [NW-1:0] nsec;
  } timespec_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           kind_i      = KIND_ADD;
  logic signed [SW-1:0] a_sec_i     = '0;
  logic signed [NW-1:0] a_nsec_i    = '0;
  logic signed [SW-1:0] b_sec_i     = '0;
  logic signed [NW-1:0] b_nsec_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [SW-1:0] res_sec_o;
  logic signed [NW-1:0] res_nsec_o;

  operands_t pending_ops[$];
  timespec_t expected_times[$];

  bit        in_taken   = 1'b0;
  bit        tx_idle_en = 1'b1;
  bit        rx_idle_en = 1'b1;
  int        tx_gap     = 0;
  int        rx_stall   = 0;
  int        hold_req   = 0;
  int        hold_seen  = 0;
  int        idle_cycles = 0;
  int        mismatch_count = 0;
  operands_t drv_ops;

  timespec_add_sub_saturating_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .a_sec_i     (a_sec_i),
    .a_nsec_i    (a_nsec_i),
    .b_sec_i     (b_sec_i),
    .b_nsec_i    (b_nsec_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_sec_o   (res_sec_o),
    .res_nsec_o  (res_nsec_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Out-of-range nanoseconds are clamped to just under one second.
  function automatic longint clamp_nsec(input logic signed [NW-1:0] raw);
    longint v;
    v = raw;
    if (v > NS_PER_SEC - 1) v = NS_PER_SEC - 1;
    if (v < -(NS_PER_SEC - 1)) v = -(NS_PER_SEC - 1);
    return v;
  endfunction

  function automatic timespec_t saturated_time(input bit high);
    timespec_t r;
    longint    n;
    n = high ? NS_PER_SEC - 1 : -(NS_PER_SEC - 1);
    r.sec  = high ? tasu_pkg::SEC_MAX : tasu_pkg::SEC_MIN;
    r.nsec = n[NW-1:0];
    return r;
  endfunction

  function automatic timespec_t predict_timespec(input operands_t op);
    timespec_t     r;
    logic [SW-1:0] s;
    longint        an, bn, n;
    bit            sub, sat, sa, sb, sr, ovf, b_nonneg, up, c, spos;
    sub = op.kind[tasu_pkg::KIND_SUB_BIT];
    sat = op.kind[tasu_pkg::KIND_SAT_BIT];
    an  = clamp_nsec(op.a_nsec);
    bn  = clamp_nsec(op.b_nsec);
    s   = sub ? op.a_sec - op.b_sec : op.a_sec + op.b_sec;
    if (sat) begin
      sa  = !op.a_sec[SW-1];
      sb  = !op.b_sec[SW-1];
      sr  = !s[SW-1];
      ovf = sub ? (sa != sb && sa != sr) : (sa == sb && sa != sr);
      if (ovf) return saturated_time(!sr);
    end
    n = sub ? an - bn : an + bn;
    // The direction of the nanosecond carry follows the sign of the
    // effective second operand.
    b_nonneg = !op.b_sec[SW-1] && bn >= 0;
    up = sub ? !b_nonneg : b_nonneg;
    if (up) begin
      c = !s[SW-1] ? (n >= NS_PER_SEC) : (n > 0);
      if (c) begin
        if (sat && s == tasu_pkg::SEC_MAX) return saturated_time(1'b1);
        s = s + 1;
        n = n - NS_PER_SEC;
      end
    end else begin
      spos = !s[SW-1] && s != '0;
      c = spos ? (n < 0) : (n <= -NS_PER_SEC);
      if (c) begin
        if (sat && s == tasu_pkg::SEC_MIN) return saturated_time(1'b0);
        s = s - 1;
        n = n + NS_PER_SEC;
      end
    end
    if (s[SW-1] && n > 0) begin
      s = s + 1;
      n = n - NS_PER_SEC;
    end else if (!s[SW-1] && s != '0 && n < 0) begin
      s = s - 1;
      n = n + NS_PER_SEC;
    end
    r.sec  = s;
    r.nsec = n[NW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [SW-1:0] got,
                                 input logic [SW-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic int pick_gap(input bit en);
    int r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SW-1:0] rand_sec();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return SW'($signed($urandom_range(0, 10)) - 5);
    if (r < 6) return tasu_pkg::SEC_MAX - SW'($urandom_range(0, 3));
    if (r < 8) return tasu_pkg::SEC_MIN + SW'($urandom_range(0, 3));
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed nanoseconds with the sign of the seconds; the rest
  // is raw noise over the whole field.
  function automatic logic [NW-1:0] rand_nsec(input logic [SW-1:0] sec);
    int          r;
    int unsigned mag;
    r = $urandom_range(0, 99);
    if (r < 12) return NW'($urandom);
    if (r < 40) mag = 999999999 - $urandom_range(0, 3);
    else if (r < 55) mag = $urandom_range(0, 3);
    else mag = $urandom_range(0, 999999999);
    if (sec[SW-1] || (sec == '0 && $urandom_range(0, 1) == 1)) return NW'(-int'(mag));
    return NW'(mag);
  endfunction

  task automatic add_ops(input logic [1:0] kind, input logic [SW-1:0] as,
                         input logic [NW-1:0] an, input logic [SW-1:0] bs,
                         input logic [NW-1:0] bn);
    operands_t op;
    op.kind   = kind;
    op.a_sec  = as;
    op.a_nsec = an;
    op.b_sec  = bs;
    op.b_nsec = bn;
    pending_ops.push_back(op);
  endtask

  task automatic add_random_ops(input int count);
    logic [SW-1:0] as, bs;
    for (int i = 0; i < count; i++) begin
      as = rand_sec();
      bs = rand_sec();
      add_ops(2'($urandom_range(0, 3)), as, rand_nsec(as), bs, rand_nsec(bs));
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || (in_valid_i && !in_taken) ||
           expected_times.size() != 0)
      @(negedge clk_i);
  endtask

  // Sender: a new transaction is offered only once the previous one is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        drv_ops = pending_ops.pop_front();
        kind_i     <= drv_ops.kind;
        a_sec_i    <= drv_ops.a_sec;
        a_nsec_i   <= drv_ops.a_nsec;
        b_sec_i    <= drv_ops.b_sec;
        b_nsec_i   <= drv_ops.b_nsec;
        in_valid_i <= 1'b1;
        tx_gap = pick_gap(tx_idle_en);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver with random back-pressure and an occasional long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        rx_stall  = LONG_HOLD;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else if (!rx_idle_en || $urandom_range(0, 99) < 70) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        rx_stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 3);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    operands_t seen;
    timespec_t want;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      seen.kind   = kind_i;
      seen.a_sec  = a_sec_i;
      seen.a_nsec = a_nsec_i;
      seen.b_sec  = b_sec_i;
      seen.b_nsec = b_nsec_i;
      expected_times.push_back(predict_timespec(seen));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_times.size() == 0) begin
        report_mismatch("result with no transaction outstanding", res_sec_o, '0);
      end else begin
        want = expected_times.pop_front();
        if (res_sec_o !== want.sec) report_mismatch("res_sec", res_sec_o, want.sec);
        if (res_nsec_o !== want.nsec)
          report_mismatch("res_nsec", SW'(res_nsec_o), SW'(want.nsec));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed transactions: carries, wrap, saturation and malformed operands.
    add_ops(KIND_ADD, 1, 500000000, 2, 700000000);
    add_ops(KIND_SUB, 1, 0, 0, 1);
    add_ops(KIND_SUB, -1, -500000000, 1, 600000000);
    add_ops(KIND_ADD, 0, 0, 0, 0);
    add_ops(KIND_ADD, tasu_pkg::SEC_MAX, 0, 1, 0);
    add_ops(KIND_SAT_ADD, tasu_pkg::SEC_MAX, 0, 1, 0);
    add_ops(KIND_SAT_SUB, tasu_pkg::SEC_MIN, 0, 1, 0);
    add_ops(KIND_SAT_ADD, tasu_pkg::SEC_MIN, 0, tasu_pkg::SEC_MIN, 0);
    add_ops(KIND_SAT_ADD, tasu_pkg::SEC_MAX, 999999999, 0, 1);
    add_ops(KIND_SAT_SUB, tasu_pkg::SEC_MIN, -999999999, 0, 1);
    add_ops(KIND_SUB, tasu_pkg::SEC_MIN, -999999999, 0, 1);
    add_ops(KIND_ADD, tasu_pkg::SEC_MAX, 999999999, 0, 1);
    add_ops(KIND_SAT_SUB, tasu_pkg::SEC_MAX, 999999999, tasu_pkg::SEC_MIN, -999999999);
    add_ops(KIND_SAT_SUB, tasu_pkg::SEC_MIN, -999999999, tasu_pkg::SEC_MAX, 999999999);
    add_ops(KIND_SAT_ADD, tasu_pkg::SEC_MAX - 1, 999999999, 1, 999999999);
    add_ops(KIND_SAT_SUB, tasu_pkg::SEC_MIN + 1, -999999999, 1, 999999999);
    add_ops(KIND_SAT_ADD, tasu_pkg::SEC_MAX, 0, 0, 999999999);
    add_ops(KIND_SAT_ADD, -1, -999999999, 0, -1);
    add_ops(KIND_ADD, 0, 999999999, 0, 999999999);
    add_ops(KIND_SUB, 0, -999999999, 0, 999999999);
    // Nanosecond fields at the ends of their encoding, beyond one second.
    add_ops(KIND_ADD, 3, {1'b0, {(NW-1){1'b1}}}, -3, {1'b1, {(NW-1){1'b0}}});
    add_ops(KIND_SAT_SUB, -2, {1'b0, {(NW-1){1'b1}}}, 4, {1'b1, {(NW-1){1'b0}}});
    // Seconds and nanoseconds of opposite signs.
    add_ops(KIND_ADD, 5, -300000000, -2, 700000000);
    add_ops(KIND_SUB, -3, 400000000, 2, -900000000);
    add_ops(KIND_SAT_ADD, -1, 999999999, 1, -999999999);
    wait_drained();

    add_random_ops(250);
    wait_drained();

    // Full rate with no idling; the receiver holds off so the pipeline fills.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req++;
    add_random_ops(200);
    wait_drained();

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    add_random_ops(200);
    repeat (40) @(negedge clk_i);
    hold_req++;
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
